// File: design/tmc_pkg.sv
// tmc_pkg: shared types, constants and the millivolt breakpoint table
// for the thermistor millivolt to celsius converter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tmc_pkg;

  // built-in table size and field widths
  localparam int unsigned BUILTIN_ENTRIES = 34;
  localparam int unsigned TBL_IDX_W       = 6;
  localparam int unsigned MV_W            = 13;
  localparam int unsigned PT_W            = 12;
  localparam int unsigned TEMP_W          = 8;
  localparam int unsigned QUOT_W          = 3;
  localparam int unsigned NUM_W           = 15;

  // temperature of entry 0 and the step between entries
  localparam int FIRST_TEMP_INT = -40;
  localparam int TEMP_STEP_INT  = 5;
  localparam logic signed [TEMP_W-1:0] FIRST_TEMP = TEMP_W'(FIRST_TEMP_INT);
  localparam logic signed [TEMP_W-1:0] TEMP_STEP  = TEMP_W'(TEMP_STEP_INT);

  // item classes decided by the front end
  localparam logic [1:0] KIND_COLD   = 2'd0;  // at or above first breakpoint
  localparam logic [1:0] KIND_HOT    = 2'd1;  // at or below last breakpoint
  localparam logic [1:0] KIND_SEARCH = 2'd2;  // inside the table, interpolate

  // one queued item
  typedef struct packed {
    logic [1:0]      kind;
    logic [MV_W-1:0] mv;
  } tmc_item_t;

  // falling breakpoints in mV, 5 degrees apart from -40 C
  function automatic logic [PT_W-1:0] mv_point(input logic [TBL_IDX_W-1:0] idx);
    logic [PT_W-1:0] pt;
    case (idx)
      6'd0:    pt = 12'd2992;
      6'd1:    pt = 12'd2969;
      6'd2:    pt = 12'd2940;
      6'd3:    pt = 12'd2904;
      6'd4:    pt = 12'd2861;
      6'd5:    pt = 12'd2809;
      6'd6:    pt = 12'd2748;
      6'd7:    pt = 12'd2677;
      6'd8:    pt = 12'd2596;
      6'd9:    pt = 12'd2503;
      6'd10:   pt = 12'd2401;
      6'd11:   pt = 12'd2290;
      6'd12:   pt = 12'd2170;
      6'd13:   pt = 12'd2045;
      6'd14:   pt = 12'd1916;
      6'd15:   pt = 12'd1784;
      6'd16:   pt = 12'd1651;
      6'd17:   pt = 12'd1520;
      6'd18:   pt = 12'd1392;
      6'd19:   pt = 12'd1269;
      6'd20:   pt = 12'd1153;
      6'd21:   pt = 12'd1045;
      6'd22:   pt = 12'd944;
      6'd23:   pt = 12'd852;
      6'd24:   pt = 12'd767;
      6'd25:   pt = 12'd691;
      6'd26:   pt = 12'd621;
      6'd27:   pt = 12'd559;
      6'd28:   pt = 12'd502;
      6'd29:   pt = 12'd452;
      6'd30:   pt = 12'd407;
      6'd31:   pt = 12'd366;
      6'd32:   pt = 12'd330;
      6'd33:   pt = 12'd297;
      default: pt = 12'd0;
    endcase
    return pt;
  endfunction

endpackage

`default_nettype wire

// File: design/tmc_front.sv
// tmc_front: accepts input beats and sorts them into clamp or search items
// depends on tmc_pkg
`timescale 1ns / 1ps
`default_nettype none

module tmc_front #(
  parameter int unsigned N_USED = 34
) (
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [tmc_pkg::MV_W-1:0] in_mv,
  input  wire logic                  q_full,
  output logic                       q_push,
  output tmc_pkg::tmc_item_t         q_item
);
  import tmc_pkg::*;

  localparam logic [PT_W-1:0] FIRST_PT = mv_point(TBL_IDX_W'(0));
  localparam logic [PT_W-1:0] LAST_PT  = mv_point(TBL_IDX_W'(N_USED - 1));

  // take a beat whenever the queue has room
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // classify against the two table ends
  always_comb begin
    q_item.mv = in_mv;
    if (in_mv >= {1'b0, FIRST_PT}) begin
      q_item.kind = KIND_COLD;
    end else if (in_mv <= {1'b0, LAST_PT}) begin
      q_item.kind = KIND_HOT;
    end else begin
      q_item.kind = KIND_SEARCH;
    end
  end

endmodule

`default_nettype wire

// File: design/tmc_queue.sv
// tmc_queue: two-entry queue of classified items between front and back end
// depends on tmc_pkg
`timescale 1ns / 1ps
`default_nettype none

module tmc_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire tmc_pkg::tmc_item_t push_item,
  output logic                    full,
  input  wire logic               pop,
  output logic                    pop_valid,
  output tmc_pkg::tmc_item_t      pop_item
);
  import tmc_pkg::*;

  tmc_item_t  slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full      = (cnt_r == 2'd2);
  assign pop_valid = (cnt_r != 2'd0);
  assign pop_item  = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // payload slots
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// File: design/tmc_back.sv
// tmc_back: walks the breakpoint table, divides the segment offset and
// holds the result beat; depends on tmc_pkg
`timescale 1ns / 1ps
`default_nettype none

module tmc_back #(
  parameter int unsigned N_USED = 34
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         q_valid,
  input  wire tmc_pkg::tmc_item_t           q_item,
  output logic                              q_pop,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [tmc_pkg::TEMP_W-1:0] out_temp
);
  import tmc_pkg::*;

  localparam int unsigned IDX_W = (N_USED > 2) ? $clog2(N_USED) : 1;
  localparam logic signed [TEMP_W-1:0] LAST_TEMP =
    TEMP_W'(FIRST_TEMP_INT + TEMP_STEP_INT * (N_USED - 1));

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_DIV    = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  logic [1:0]               state_r, state_nxt;
  logic [IDX_W-1:0]         k_r, k_nxt;
  logic signed [TEMP_W-1:0] base_r, base_nxt;
  logic [MV_W-1:0]          mv_r, mv_nxt;
  logic [NUM_W-1:0]         rem_r, rem_nxt;
  logic [PT_W-1:0]          span_r, span_nxt;
  logic [1:0]               step_r, step_nxt;
  logic [QUOT_W-2:0]        quot_r, quot_nxt;
  logic signed [TEMP_W-1:0] res_r, res_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [TEMP_W-1:0] out_temp_r, out_temp_nxt;

  logic [PT_W-1:0]  pt_k, pt_prev;
  logic [PT_W-1:0]  diff;
  logic [MV_W-1:0]  diff_w;
  logic [NUM_W-1:0] span_sh;
  logic             ge;
  logic             out_free;

  // table reads at the current and previous breakpoint
  assign pt_k    = mv_point(TBL_IDX_W'(k_r));
  assign pt_prev = mv_point(TBL_IDX_W'(k_r - IDX_W'(1)));
  assign diff_w  = {1'b0, pt_prev} - mv_r;
  assign diff    = diff_w[PT_W-1:0];

  // restoring divide step, quotient fits in three bits
  assign span_sh = {{(NUM_W - PT_W){1'b0}}, span_r} << step_r;
  assign ge      = (span_r != '0) && (rem_r >= span_sh);

  assign out_free  = !out_valid_r || out_ready;
  assign q_pop     = (state_r == ST_IDLE) && q_valid;
  assign out_valid = out_valid_r;
  assign out_temp  = out_temp_r;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    base_nxt      = base_r;
    mv_nxt        = mv_r;
    rem_nxt       = rem_r;
    span_nxt      = span_r;
    step_nxt      = step_r;
    quot_nxt      = quot_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_temp_nxt  = out_temp_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          mv_nxt   = q_item.mv;
          k_nxt    = IDX_W'(1);
          base_nxt = FIRST_TEMP;
          case (q_item.kind)
            KIND_COLD: begin
              res_nxt   = FIRST_TEMP;
              state_nxt = ST_DONE;
            end
            KIND_HOT: begin
              res_nxt   = LAST_TEMP;
              state_nxt = ST_DONE;
            end
            KIND_SEARCH: begin
              state_nxt = ST_SEARCH;
            end
            default: begin
              res_nxt   = FIRST_TEMP;
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_SEARCH: begin
        if ({1'b0, pt_k} < mv_r) begin
          // segment found: offset times five over the span
          rem_nxt   = {1'b0, diff, 2'b00} + {{(NUM_W - PT_W){1'b0}}, diff};
          span_nxt  = pt_prev - pt_k;
          step_nxt  = 2'd2;
          quot_nxt  = '0;
          state_nxt = ST_DIV;
        end else if (k_r == IDX_W'(N_USED - 1)) begin
          res_nxt   = LAST_TEMP;
          state_nxt = ST_DONE;
        end else begin
          k_nxt    = k_r + IDX_W'(1);
          base_nxt = base_r + TEMP_STEP;
        end
      end
      ST_DIV: begin
        if (ge) begin
          rem_nxt = rem_r - span_sh;
        end
        quot_nxt = {quot_r[0], ge};
        if (step_r == 2'd0) begin
          res_nxt   = base_r + TEMP_W'({quot_r, ge});
          state_nxt = ST_DONE;
        end else begin
          step_nxt = step_r - 2'd1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_temp_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    base_r     <= base_nxt;
    mv_r       <= mv_nxt;
    rem_r      <= rem_nxt;
    span_r     <= span_nxt;
    step_r     <= step_nxt;
    quot_r     <= quot_nxt;
    res_r      <= res_nxt;
    out_temp_r <= out_temp_nxt;
  end

endmodule

`default_nettype wire

// File: design/thermistor_mv_to_celsius.sv
// thermistor_mv_to_celsius: millivolts in, whole degrees celsius out, by
// table walk with linear interpolation (N_USED is TABLE_ENTRIES capped at
// 34); search walks one breakpoint per cycle, then a restoring divide runs;
// the back end pops a new item only once its last result is in the output register.
// synchronous active-low reset empties the queue and drops any pending result
`timescale 1ns / 1ps
`default_nettype none

module thermistor_mv_to_celsius #(
  parameter int unsigned TABLE_ENTRIES = 34
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [12:0] millivolts, [15:13] zero
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata   // [7:0] temp_celsius
);
  import tmc_pkg::*;

  localparam int unsigned N_USED =
    (TABLE_ENTRIES < BUILTIN_ENTRIES) ? TABLE_ENTRIES : BUILTIN_ENTRIES;

  logic                     q_full;
  logic                     q_push;
  tmc_item_t                push_item;
  logic                     q_pop;
  logic                     q_valid;
  tmc_item_t                pop_item;
  logic signed [TEMP_W-1:0] temp;

  // front end: accept and classify
  tmc_front #(.N_USED(N_USED)) u_front (
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_mv    (in_tdata[MV_W-1:0]),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (push_item)
  );

  // queue between the two sides
  tmc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_item  (pop_item)
  );

  // back end: search, divide, result register
  tmc_back #(.N_USED(N_USED)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (pop_item),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_temp  (temp)
  );

  assign out_tdata = temp;

endmodule

`default_nettype wire

// File: design/tmc_checker.sv
// tmc_checker: port-level checks on the converter, attached by bind
// depends on thermistor_mv_to_celsius
`timescale 1ns / 1ps
`default_nettype none

module tmc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [7:0]  out_tdata
);

  // a stalled result beat stays up
  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  // a stalled result beat keeps its value
  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result beat changed while stalled");

  // results stay within the table's temperature span
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata) >= -8'sd40) && ($signed(out_tdata) <= 8'sd125))
    else $error("temperature outside table span");

  // no result right out of reset
  a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result beat right after reset");

  // handshake outputs always known once out of reset
  a_handshake_known: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown({in_tready, out_tvalid}))
    else $error("handshake output unknown");

endmodule

bind thermistor_mv_to_celsius tmc_checker u_tmc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// File: verif/thermistor_mv_to_celsius_tb.sv
// thermistor_mv_to_celsius_tb: self-checking bench for the millivolt to celsius converter
// depends on tmc_pkg and thermistor_mv_to_celsius; predicts every beat from its
// own breakpoint table and compares results in order
`timescale 1ns / 1ps

module thermistor_mv_to_celsius_tb;
  import tmc_pkg::*;

  localparam int unsigned TABLE_ENTRIES  = 34;
  localparam int unsigned ENTRIES_USED   =
    (TABLE_ENTRIES < 34) ? ((TABLE_ENTRIES < 2) ? 2 : TABLE_ENTRIES) : 34;
  localparam int          DRAIN_CYCLES   = TABLE_ENTRIES + 16;
  localparam int          WATCHDOG_LIMIT = 3000;
  localparam int          REPORT_LIMIT   = 10;
  localparam int          MV_MAX         = (1 << MV_W) - 1;

  // one accepted reading and the temperature it should give
  typedef struct packed {
    logic [MV_W-1:0]          mv;
    logic signed [TEMP_W-1:0] temp;
  } reading_t;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [15:0]       in_tdata;   // [12:0] millivolts, [15:13] zero
  logic              out_tvalid;
  logic              out_tready;
  logic [7:0]        out_tdata;  // [7:0] temp_celsius

  // falling divider voltages, 5 degrees apart from -40 C
  int unsigned mv_breakpoint [34] = '{
    2992, 2969, 2940, 2904, 2861, 2809, 2748, 2677, 2596, 2503,
    2401, 2290, 2170, 2045, 1916, 1784, 1651, 1520, 1392, 1269,
    1153, 1045,  944,  852,  767,  691,  621,  559,  502,  452,
     407,  366,  330,  297
  };

  reading_t pending_readings [$];
  reading_t got_reading;
  int       error_count;
  int       idle_run;
  int       reader_hold_cycles;
  bit       tx_idle_en;
  bit       rx_idle_en;

  thermistor_mv_to_celsius #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // temperature of a table entry
  function automatic int entry_celsius(input int unsigned idx);
    return -40 + 5 * int'(idx);
  endfunction

  // clamp at the table ends, else interpolate inside the first segment below mv
  function automatic logic signed [TEMP_W-1:0] celsius_for_mv(input logic [MV_W-1:0] mv);
    int unsigned k;
    int unsigned upper;
    int unsigned span;
    int unsigned steps;
    if (mv >= mv_breakpoint[0]) return TEMP_W'(entry_celsius(0));
    if (mv <= mv_breakpoint[ENTRIES_USED-1]) return TEMP_W'(entry_celsius(ENTRIES_USED-1));
    for (k = 1; k < ENTRIES_USED; k++) begin
      if (mv_breakpoint[k] < mv) begin
        upper = mv_breakpoint[k-1];
        span  = upper - mv_breakpoint[k];
        steps = 0;
        if (span != 0 && upper >= mv) steps = ((upper - mv) * 5) / span;
        return TEMP_W'(entry_celsius(k-1) + int'(steps));
      end
    end
    return TEMP_W'(entry_celsius(ENTRIES_USED-1));
  endfunction

  // random reading, weighted toward the table and its breakpoints
  function automatic logic [MV_W-1:0] pick_reading();
    int mv;
    case ($urandom_range(0, 9))
      0:       mv = $urandom_range(0, 297);
      1:       mv = $urandom_range(2992, MV_MAX);
      2, 3:    mv = int'(mv_breakpoint[$urandom_range(0, 33)]) + $urandom_range(0, 2) - 1;
      default: mv = $urandom_range(297, 2992);
    endcase
    return MV_W'(mv);
  endfunction

  // offer one reading, after an optional idle burst, and log it once accepted
  task automatic send_reading(input logic [MV_W-1:0] mv);
    int gap;
    gap = 0;
    if (tx_idle_en && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 7);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= 16'(mv);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_readings.push_back('{mv: mv, temp: celsius_for_mv(mv)});
  endtask

  // stop offering and wait for every outstanding result
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  // range ends, breakpoint neighbors, out-of-range values and bit patterns
  task automatic test_directed_edges();
    int unsigned edge_mv [21] = '{
      0, 1, 296, 297, 298, 329, 330, 331, 1915, 1916, 2968,
      2969, 2970, 2991, 2992, 2993, 4999, 5000, 4096, 5461, 8191
    };
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    foreach (edge_mv[i]) send_reading(MV_W'(edge_mv[i]));
    wait_for_drain();
  endtask

  // reader holds off long while readings keep coming, so the input stalls
  task automatic test_backpressure_fill();
    tx_idle_en = 1'b0;
    reader_hold_cycles = 400;
    repeat (24) send_reading(pick_reading());
    wait_for_drain();
  endtask

  // random readings in blocks, idling on in some blocks and off in others
  task automatic test_random_mix();
    repeat (14) begin
      tx_idle_en = ($urandom_range(0, 2) != 0);
      rx_idle_en = ($urandom_range(0, 2) != 0);
      repeat (100) send_reading(pick_reading());
      if ($urandom_range(0, 3) == 0) wait_for_drain();
    end
  endtask

  // closing stretch at full rate on both sides
  task automatic test_random_no_idle();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (300) send_reading(pick_reading());
    wait_for_drain();
  endtask

  // result reader: idle bursts, or one long hold when asked
  initial begin
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (reader_hold_cycles != 0) begin
        out_tready <= 1'b0;
        repeat (reader_hold_cycles) @(posedge clk);
        reader_hold_cycles = 0;
        out_tready <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  // compare each result beat with the oldest outstanding reading
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_readings.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT)
          $display("%0t: unexpected result beat, got %0d", $realtime, $signed(out_tdata));
      end else begin
        got_reading = pending_readings.pop_front();
        if (out_tdata !== got_reading.temp) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display("%0t: mv %0d expected %0d got %0d", $realtime, got_reading.mv,
                     got_reading.temp, $signed(out_tdata));
        end
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_run <= 0;
    end else if (idle_run >= WATCHDOG_LIMIT) begin
      $display("thermistor_mv_to_celsius_tb: errors");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  // test sequence
  initial begin
    rst_n              = 1'b0;
    in_tvalid          = 1'b0;
    in_tdata           = '0;
    error_count        = 0;
    idle_run           = 0;
    reader_hold_cycles = 0;
    tx_idle_en         = 1'b0;
    rx_idle_en         = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_edges();
    test_backpressure_fill();
    test_random_mix();
    test_random_no_idle();

    // let any stray beat show up before judging
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_readings.size() == 0) begin
      $display("thermistor_mv_to_celsius_tb: clean");
    end else begin
      $display("thermistor_mv_to_celsius_tb: errors");
    end
    $finish;
  end

endmodule
